>>> hw/rtl/audio_peak_limiter_core_macros.svh
// Assertion helpers for the peak limiter core.
`ifndef AUDIO_PEAK_LIMITER_CORE_MACROS_SVH
`define AUDIO_PEAK_LIMITER_CORE_MACROS_SVH

// Check on every clock edge outside reset.
`define APL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, reset included.
`define APL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/apl_pkg.sv
package apl_pkg;

  localparam int unsigned MAX_CHANNELS_DEF = 8;
  localparam int unsigned IN_FIELDS        = 8;
  localparam int unsigned SAMPLE_W         = 24;
  localparam int unsigned GAIN_W           = 24;
  localparam int unsigned HOLD_W           = 20;
  localparam int unsigned REL_W            = 20;
  localparam int unsigned CHAN_W           = 4;
  localparam int unsigned CFG_IDX_W        = 4;
  localparam int unsigned CFG_DATA_W       = 24;
  localparam int unsigned DIV_N_W          = 48;
  localparam int unsigned DIV_D_W          = 32;
  localparam int unsigned EXP_STEPS        = 30;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN    = 4'd3;

  localparam logic [23:0] ONE_Q23 = 24'h80_0000;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [REL_W-1:0] REL_MIN = 20'd16;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PEAK, ST_MERGE, ST_LEVEL, ST_TRIG, ST_DIVR, ST_LOGI,
    ST_LOGS, ST_DIVE, ST_EXPS, ST_FACT, ST_REL, ST_RELW, ST_OUTM
  } apl_state_e;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } apl_div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } apl_div_stat_t;

  typedef logic [EXP_STEPS-1:0][31:0] exp_tab_t;

  // Floor square root by the bit-pair method.
  function automatic logic [63:0] isqrt64_f(logic [63:0] x);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = x;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Terms 2^(2^-i), i = 1..30, in Q2.30, each the root of the one before.
  function automatic exp_tab_t exp_tab_f();
    exp_tab_t    t;
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int k = 0; k < EXP_STEPS; k++) begin
      r = isqrt64_f(r << 30);
      t[k] = r[31:0];
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_tab_f();

endpackage

>>> hw/rtl/apl_lane.sv
module apl_lane (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic                          active_i,
  input  logic [apl_pkg::SAMPLE_W-1:0]  sample_i,
  output logic [apl_pkg::SAMPLE_W-1:0]  mag_o
);
  import apl_pkg::*;

  logic [SAMPLE_W-1:0] mag_d, mag_q;

  // Take the magnitude; full-scale negative maps to exactly one.
  always_comb begin
    mag_d = sample_i[SAMPLE_W-1] ? (~sample_i + 1'b1) : sample_i;
    if (!active_i) mag_d = '0;
  end

  // Hold the lane result for the merge stage.
  always_ff @(posedge clk_i) begin
    if (load_i) mag_q <= mag_d;
  end

  assign mag_o = mag_q;
endmodule

>>> hw/rtl/apl_merge.sv
module apl_merge (
  input  logic                                      clk_i,
  input  logic                                      load_i,
  input  logic [apl_pkg::IN_FIELDS-1:0][apl_pkg::SAMPLE_W-1:0] mag_i,
  output logic [apl_pkg::SAMPLE_W-1:0]              peak_o
);
  import apl_pkg::*;

  logic [3:0][SAMPLE_W-1:0] lvl1;
  logic [1:0][SAMPLE_W-1:0] lvl2;
  logic [SAMPLE_W-1:0]      peak_d, peak_q;

  // Reduce the lanes pairwise in a three level tree.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lvl1[k] = (mag_i[2*k] > mag_i[2*k+1]) ? mag_i[2*k] : mag_i[2*k+1];
    end
    for (int k = 0; k < 2; k++) begin
      lvl2[k] = (lvl1[2*k] > lvl1[2*k+1]) ? lvl1[2*k] : lvl1[2*k+1];
    end
    peak_d = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) peak_q <= peak_d;
  end

  assign peak_o = peak_q;
endmodule

>>> hw/rtl/apl_div.sv
module apl_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  apl_pkg::apl_div_ctl_t         ctl_i,
  output apl_pkg::apl_div_stat_t        stat_o,
  output logic [apl_pkg::DIV_N_W-1:0]   quot_o
);
  import apl_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_N_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_N_W - 1);

  logic [DIV_D_W-1:0] rem_q, rem_d;
  logic [DIV_N_W-1:0] quo_q, quo_d;
  logic [DIV_D_W-1:0] dvs_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q, done_q;
  logic [DIV_D_W:0]   trial;
  logic               fit;

  // One restoring step: shift in a dividend bit, subtract if it fits.
  always_comb begin
    trial = {rem_q, quo_q[DIV_N_W-1]};
    fit   = (trial >= {1'b0, dvs_q});
    rem_d = fit ? DIV_D_W'(trial - {1'b0, dvs_q}) : trial[DIV_D_W-1:0];
    quo_d = {quo_q[DIV_N_W-2:0], fit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Load operands on start, advance while busy.
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q <= '0;
      quo_q <= ctl_i.dividend;
      dvs_q <= ctl_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;
endmodule

>>> hw/rtl/audio_peak_limiter_core.sv
// Channel  Handshake              Payload
// in       in_valid_i/in_stall_o  sample_ch0_i .. sample_ch7_i (Q1.23)
// out      out_valid_o/out_stall_i frame_gain_o (Q8.16)
// cfg      cfg_we_i               cfg_idx_i, cfg_data_i
//
// A frame that does not trip the limiter passes from accept through the peak,
// merge, level, trigger, release and output states, plus a release-write state
// when it takes a release step. A new peak adds two 48-step passes of the serial
// divider (reciprocal, then log over release length), 30 log squarings and
// 30 exp products; the squarings and products share the one 32x32 multiplier.
// One frame is in flight at a time; the next is taken once the result is
// registered, even while that result is still stalled.
// Reset clears the state and loads the register defaults; no clearing pass.
module audio_peak_limiter_core #(
  parameter int unsigned MAX_CHANNELS = apl_pkg::MAX_CHANNELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [apl_pkg::SAMPLE_W-1:0]   sample_ch0_i,
  input  logic [apl_pkg::SAMPLE_W-1:0]   sample_ch1_i,
  input  logic [apl_pkg::SAMPLE_W-1:0]   sample_ch2_i,
  input  logic [apl_pkg::SAMPLE_W-1:0]   sample_ch3_i,
  input  logic [apl_pkg::SAMPLE_W-1:0]   sample_ch4_i,
  input  logic [apl_pkg::SAMPLE_W-1:0]   sample_ch5_i,
  input  logic [apl_pkg::SAMPLE_W-1:0]   sample_ch6_i,
  input  logic [apl_pkg::SAMPLE_W-1:0]   sample_ch7_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [apl_pkg::GAIN_W-1:0]     frame_gain_o,
  input  logic                           cfg_we_i,
  input  logic [apl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [apl_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import apl_pkg::*;
  `include "audio_peak_limiter_core_macros.svh"

  localparam int unsigned NLANE = (MAX_CHANNELS < IN_FIELDS) ? MAX_CHANNELS : IN_FIELDS;
  localparam logic [CHAN_W:0] NLANE_C = (CHAN_W+1)'(NLANE);

  apl_state_e state_q, state_d;

  logic [GAIN_W-1:0]  gain_q;
  logic [HOLD_W-1:0]  hold_cfg_q;
  logic [REL_W-1:0]   rel_cfg_q;
  logic [CHAN_W-1:0]  chan_q;

  logic [23:0]  att_q, prev_q;
  logic [HOLD_W-1:0] hold_q;
  logic [31:0]  factor_q, level_q, res_q;
  logic [30:0]  m_q;
  logic [32:0]  l_q;
  logic [29:0]  e_q;
  logic [4:0]   it_q;
  logic [55:0]  prod_q;
  logic         out_valid_q;
  logic [GAIN_W-1:0] out_q;

  logic [IN_FIELDS-1:0][SAMPLE_W-1:0] samples, mags;
  logic [SAMPLE_W-1:0] peak;
  logic [CHAN_W:0]     n_act;
  logic                accept, slot_free, trig, last_it;
  logic                lane_load, merge_load;
  logic [31:0]         mul_a, mul_b;
  logic [63:0]         mul_p;
  apl_div_ctl_t        div_ctl;
  apl_div_stat_t       div_st;
  logic [DIV_N_W-1:0]  div_q;
  logic [REL_W-1:0]    rel_eff;
  logic [2:0]          top_off;
  logic [31:0]         sq;
  logic [56:0]         rel_sum;
  logic [26:0]         rel_a;
  logic [24:0]         g_raw;

  assign samples = {sample_ch7_i, sample_ch6_i, sample_ch5_i, sample_ch4_i,
                    sample_ch3_i, sample_ch2_i, sample_ch1_i, sample_ch0_i};

  assign accept    = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign n_act     = ({1'b0, chan_q} > NLANE_C) ? NLANE_C : {1'b0, chan_q};
  assign rel_eff   = (rel_cfg_q < REL_MIN) ? REL_MIN : rel_cfg_q;
  assign mul_p     = mul_a * mul_b;
  assign trig      = mul_p[55:0] > 56'h4000_0000_0000;
  assign last_it   = (it_q == 5'(EXP_STEPS - 1));
  assign sq        = mul_p[61:30];
  assign rel_sum   = {1'b0, prod_q} + 57'(ONE_Q30 - 32'd1);
  assign rel_a     = rel_sum[56:30];
  assign g_raw     = mul_p[47:23];

  // Lanes: one magnitude per channel, then the max tree.
  for (genvar i = 0; i < IN_FIELDS; i++) begin : g_lane
    apl_lane u_lane (
      .clk_i    (clk_i),
      .load_i   (lane_load),
      .active_i ((i < NLANE) && ((CHAN_W+1)'(i) < n_act)),
      .sample_i (samples[i]),
      .mag_o    (mags[i])
    );
  end

  apl_merge u_merge (
    .clk_i  (clk_i),
    .load_i (merge_load),
    .mag_i  (mags),
    .peak_o (peak)
  );

  apl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .stat_o (div_st),
    .quot_o (div_q)
  );

  // Find the leading bit of the level among bits 30..23.
  always_comb begin
    top_off = '0;
    for (int k = 0; k < 8; k++) begin
      if (level_q[23+k]) top_off = 3'(k);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_PEAK;
      ST_PEAK:  state_d = ST_MERGE;
      ST_MERGE: state_d = ST_LEVEL;
      ST_LEVEL: state_d = ST_TRIG;
      ST_TRIG:  state_d = trig ? ST_DIVR : ST_REL;
      ST_DIVR:  if (div_st.done) state_d = ST_LOGI;
      ST_LOGI:  state_d = ST_LOGS;
      ST_LOGS:  if (last_it) state_d = ST_DIVE;
      ST_DIVE:  if (div_st.done) state_d = ST_EXPS;
      ST_EXPS:  if (last_it) state_d = ST_FACT;
      ST_FACT:  state_d = ST_REL;
      ST_REL: begin
        if (hold_q == '0 && factor_q != '0) state_d = ST_RELW;
        else state_d = ST_OUTM;
      end
      ST_RELW:  state_d = ST_OUTM;
      ST_OUTM:  if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control outputs and multiplier operands.
  always_comb begin
    in_stall_o       = (state_q != ST_IDLE);
    lane_load        = accept;
    merge_load       = (state_q == ST_PEAK);
    div_ctl.start    = 1'b0;
    div_ctl.dividend = {{(DIV_N_W-33){1'b0}}, l_q};
    div_ctl.divisor  = {{(DIV_D_W-REL_W){1'b0}}, rel_eff};
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_LEVEL: begin
        mul_a = {8'b0, peak};
        mul_b = {8'b0, gain_q};
      end
      ST_TRIG: begin
        mul_a = level_q;
        mul_b = {8'b0, att_q};
        div_ctl.start    = trig;
        div_ctl.dividend = DIV_N_W'(1) << 46;
        div_ctl.divisor  = level_q;
      end
      ST_LOGS: begin
        mul_a = {1'b0, m_q};
        mul_b = {1'b0, m_q};
        // Start the divide with the last log bit included.
        div_ctl.start    = last_it;
        div_ctl.dividend = DIV_N_W'({l_q[31:0], sq[31]});
      end
      ST_EXPS: begin
        mul_a = res_q;
        mul_b = EXP_TAB[it_q];
      end
      ST_REL: begin
        mul_a = {8'b0, att_q};
        mul_b = factor_q;
      end
      ST_OUTM: begin
        mul_a = {8'b0, prev_q};
        mul_b = {8'b0, gain_q};
      end
      default: ;
    endcase
  end

  // State, registers and datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_q      <= 24'd65536;
      hold_cfg_q  <= 20'd1200;
      rel_cfg_q   <= 20'd4800;
      chan_q      <= 4'd2;
      att_q       <= ONE_Q23;
      hold_q      <= '0;
      factor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GAIN:    gain_q     <= cfg_data_i;
          CFG_HOLD:    hold_cfg_q <= cfg_data_i[HOLD_W-1:0];
          CFG_RELEASE: rel_cfg_q  <= cfg_data_i[REL_W-1:0];
          CFG_CHAN:    chan_q     <= cfg_data_i[CHAN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_DIVR: if (div_st.done) begin
          att_q  <= div_q[23:0];
          hold_q <= hold_cfg_q;
        end
        ST_FACT: factor_q <= (res_q <= ONE_Q30) ? (ONE_Q30 + 32'd1) : res_q;
        ST_REL:  if (hold_q != '0) hold_q <= hold_q - 1'b1;
        ST_RELW: begin
          if (rel_a > 27'(ONE_Q23)) begin
            factor_q <= '0;
            att_q    <= ONE_Q23;
          end else begin
            att_q <= rel_a[23:0];
          end
        end
        ST_OUTM: if (slot_free) out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload and iteration registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LEVEL: level_q <= mul_p[47:16];
      ST_LOGI: begin
        m_q  <= 31'(level_q[30:0] << (3'd7 - top_off));
        l_q  <= {30'b0, top_off};
        it_q <= '0;
      end
      ST_LOGS: begin
        m_q  <= sq[31] ? sq[31:1] : sq[30:0];
        l_q  <= {l_q[31:0], sq[31]};
        it_q <= it_q + 1'b1;
      end
      ST_DIVE: begin
        e_q   <= div_q[29:0];
        res_q <= ONE_Q30;
        it_q  <= '0;
      end
      ST_EXPS: begin
        if (e_q[5'(EXP_STEPS - 1) - it_q]) res_q <= sq;
        it_q <= it_q + 1'b1;
      end
      ST_REL: begin
        prev_q <= att_q;
        prod_q <= mul_p[55:0];
      end
      ST_OUTM: if (slot_free) out_q <= g_raw[24] ? {GAIN_W{1'b1}} : g_raw[23:0];
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign frame_gain_o = out_q;

  `APL_ASSERT(a_att_range, (att_q != '0) && (att_q <= ONE_Q23), "attenuation out of range")
  `APL_ASSERT(a_div_done_state, div_st.done |-> (state_q == ST_DIVR || state_q == ST_DIVE), "divider result with no consumer")
  `APL_ASSERT(a_factor_above_one, (state_q == ST_FACT) |=> (factor_q > ONE_Q30), "release factor not above one")
  `APL_ASSERT_ALWAYS(a_busy_stall, div_st.busy |-> in_stall_o, "input taken while divider busy")
endmodule
